// ----- src/bmhq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int KEY_W          = 32;
  localparam int VTX_W          = 16;
  localparam int COUNT_W        = 11;
  localparam int CFG_W          = 11;
  localparam int HEAP_DEPTH_DEF = 1024;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [VTX_W-1:0]   vtx_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CFG_W-1:0]   cfg_t;

  localparam cfg_t CAP_RESET = cfg_t'(1024);

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic mode;
    vtx_t vertex_id;
    key_t distance_key;
  } req_t;

  typedef struct packed {
    vtx_t    popped_vertex;
    status_t status;
    count_t  entry_count;
  } rsp_t;

  // One heap slot as stored in memory.
  typedef struct packed {
    vtx_t vtx;
    key_t key;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_ROOT,
    S_EX_LAST,
    S_EX_LOAD,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DN_SEL,
    S_RESP
  } state_t;

endpackage

// ----- src/bmhq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ram
// Heap slot store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int DEPTH = bmhq_pkg::HEAP_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  bmhq_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output bmhq_pkg::entry_t         rdata
);

  bmhq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/binary_min_heap_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Array-based binary min-heap of (vertex, distance) pairs, keyed by distance.
// ----------------------------------------------------------------------------
// Usage:
// A request word on req (req_valid / req_stall) either inserts a pair
// (mode insert) or extracts the minimum (mode extract). Every request gives
// exactly one response word on rsp (rsp_valid / rsp_stall) carrying the
// extracted vertex, a status and the entry count after the operation.
// The block takes one request at a time: req_stall is high from acceptance
// until the response has been loaded into the output register. An insert reads
// and compares the parent at each level it climbs; an extract reads the root
// and the last slot, then at each level it descends reads both children and
// compares; a refused request goes straight to the response. The steps follow
// from the memory's single registered read port and one reused key comparator.
// The response register lets a new request be accepted while the previous
// response is still stalled; a finished operation waits for that register.
// The capacity register (cfg_valid / cfg_ready / cfg_data) may be written
// while idle. Synchronous reset empties the heap, drops any pending response
// and sets the capacity to 1024. No clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
  parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bmhq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bmhq_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  bmhq_pkg::cfg_t cfg_data
);

  // Slot index width, count width (holds HEAP_DEPTH itself), child index width.
  localparam int IDX_W = $clog2(HEAP_DEPTH);
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int LW    = IDX_W + 2;
  localparam int EW    = (CNT_W > bmhq_pkg::CFG_W) ? CNT_W : bmhq_pkg::CFG_W;

  bmhq_pkg::state_t  state, state_next;
  logic [CNT_W-1:0]  heap_size, heap_size_next;
  bmhq_pkg::cfg_t    cap_lim;
  logic [IDX_W-1:0]  hole, hole_next;          // slot the moving entry would fill
  bmhq_pkg::entry_t  x, x_next;                // entry being sifted
  bmhq_pkg::entry_t  child, child_next;        // best child seen at this level
  logic [IDX_W-1:0]  child_idx, child_idx_next;
  bmhq_pkg::vtx_t    res_vtx, res_vtx_next;
  bmhq_pkg::status_t res_status, res_status_next;
  bmhq_pkg::rsp_t    rsp_q;
  logic              rsp_valid_q;
  logic              rsp_load;

  // Memory port signals.
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  bmhq_pkg::entry_t  mem_wdata, mem_rdata;

  // The one comparator that every sift step shares.
  bmhq_pkg::key_t    cmp_a, cmp_b;
  logic              cmp_lt;

  logic              req_fire;
  logic              full;
  logic [LW-1:0]     l_ext, r_ext, size_ext;
  logic [IDX_W-1:0]  parent;

  bmhq_ram #(
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req_stall = (state != bmhq_pkg::S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign cfg_ready = (state == bmhq_pkg::S_IDLE);

  assign rsp_valid = rsp_valid_q;
  assign rsp       = rsp_q;

  // The insert is refused at the programmed limit or at the store depth.
  assign full = (EW'(heap_size) >= EW'(cap_lim)) || (heap_size >= CNT_W'(HEAP_DEPTH));

  assign l_ext    = LW'({hole, 1'b1});
  assign r_ext    = l_ext + LW'(1);
  assign size_ext = LW'(heap_size);
  assign parent   = (hole - IDX_W'(1)) >> 1;

  assign cmp_lt = (cmp_a < cmp_b);

  always_comb begin
    state_next      = state;
    heap_size_next  = heap_size;
    hole_next       = hole;
    x_next          = x;
    child_next      = child;
    child_idx_next  = child_idx;
    res_vtx_next    = res_vtx;
    res_status_next = res_status;
    rsp_load        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = hole;
    mem_wdata       = x;
    mem_raddr       = parent;
    cmp_a           = child.key;
    cmp_b           = x.key;

    case (state)
      bmhq_pkg::S_IDLE: begin
        if (req_fire) begin
          res_vtx_next    = '0;
          res_status_next = bmhq_pkg::ST_OK;
          if (req.mode == bmhq_pkg::MODE_INSERT) begin
            if (full) begin
              res_status_next = bmhq_pkg::ST_FULL;
              state_next      = bmhq_pkg::S_RESP;
            end else begin
              x_next         = '{vtx: req.vertex_id, key: req.distance_key};
              hole_next      = heap_size[IDX_W-1:0];
              heap_size_next = heap_size + CNT_W'(1);
              state_next     = bmhq_pkg::S_UP_RD;
            end
          end else begin
            if (heap_size == '0) begin
              res_status_next = bmhq_pkg::ST_EMPTY;
              state_next      = bmhq_pkg::S_RESP;
            end else begin
              heap_size_next = heap_size - CNT_W'(1);
              state_next     = bmhq_pkg::S_EX_ROOT;
            end
          end
        end
      end

      // Sift up: fetch the parent of the hole, or settle at the root.
      bmhq_pkg::S_UP_RD: begin
        if (hole == '0) begin
          mem_we     = 1'b1;
          state_next = bmhq_pkg::S_RESP;
        end else begin
          mem_raddr  = parent;
          state_next = bmhq_pkg::S_UP_CMP;
        end
      end

      bmhq_pkg::S_UP_CMP: begin
        cmp_a = x.key;
        cmp_b = mem_rdata.key;
        mem_we = 1'b1;
        if (cmp_lt) begin
          // Parent is strictly greater: it moves down into the hole.
          mem_wdata  = mem_rdata;
          hole_next  = parent;
          state_next = bmhq_pkg::S_UP_RD;
        end else begin
          state_next = bmhq_pkg::S_RESP;
        end
      end

      bmhq_pkg::S_EX_ROOT: begin
        mem_raddr  = '0;
        state_next = bmhq_pkg::S_EX_LAST;
      end

      bmhq_pkg::S_EX_LAST: begin
        res_vtx_next = mem_rdata.vtx;
        mem_raddr    = heap_size[IDX_W-1:0];
        state_next   = bmhq_pkg::S_EX_LOAD;
      end

      bmhq_pkg::S_EX_LOAD: begin
        x_next     = mem_rdata;
        hole_next  = '0;
        state_next = bmhq_pkg::S_DN_RDL;
      end

      // Sift down: fetch the left child, or settle if the hole is a leaf.
      bmhq_pkg::S_DN_RDL: begin
        if (l_ext >= size_ext) begin
          mem_we     = 1'b1;
          state_next = bmhq_pkg::S_RESP;
        end else begin
          mem_raddr  = l_ext[IDX_W-1:0];
          state_next = bmhq_pkg::S_DN_RDR;
        end
      end

      bmhq_pkg::S_DN_RDR: begin
        child_next     = mem_rdata;
        child_idx_next = l_ext[IDX_W-1:0];
        if (r_ext < size_ext) begin
          mem_raddr  = r_ext[IDX_W-1:0];
          state_next = bmhq_pkg::S_DN_CMP;
        end else begin
          state_next = bmhq_pkg::S_DN_SEL;
        end
      end

      // Right child replaces the left only when strictly smaller.
      bmhq_pkg::S_DN_CMP: begin
        cmp_a = mem_rdata.key;
        cmp_b = child.key;
        if (cmp_lt) begin
          child_next     = mem_rdata;
          child_idx_next = r_ext[IDX_W-1:0];
        end
        state_next = bmhq_pkg::S_DN_SEL;
      end

      bmhq_pkg::S_DN_SEL: begin
        cmp_a  = child.key;
        cmp_b  = x.key;
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wdata  = child;
          hole_next  = child_idx;
          state_next = bmhq_pkg::S_DN_RDL;
        end else begin
          state_next = bmhq_pkg::S_RESP;
        end
      end

      bmhq_pkg::S_RESP: begin
        if (!rsp_valid_q || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = bmhq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bmhq_pkg::S_IDLE;
      heap_size   <= '0;
      cap_lim     <= bmhq_pkg::CAP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state     <= state_next;
      heap_size <= heap_size_next;
      if (cfg_valid && cfg_ready) begin
        cap_lim <= cfg_data;
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hole       <= hole_next;
    x          <= x_next;
    child      <= child_next;
    child_idx  <= child_idx_next;
    res_vtx    <= res_vtx_next;
    res_status <= res_status_next;
    if (rsp_load) begin
      rsp_q.popped_vertex <= res_vtx;
      rsp_q.status        <= res_status;
      rsp_q.entry_count   <= bmhq_pkg::count_t'(heap_size);
    end
  end

`ifndef SYNTHESIS
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    heap_size <= CNT_W'(HEAP_DEPTH))
    else $error("heap size exceeds store depth");

  a_size_change: assert property (@(posedge clk) disable iff (rst)
    !$stable(heap_size) |-> $past(req_fire))
    else $error("heap size changed without an accepted request");

  a_up_hole: assert property (@(posedge clk) disable iff (rst)
    (state == bmhq_pkg::S_UP_RD || state == bmhq_pkg::S_UP_CMP)
      |-> (CNT_W'(hole) < heap_size))
    else $error("sift-up hole outside the heap");

  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == bmhq_pkg::ST_EMPTY)
      |-> (rsp.entry_count == '0 && rsp.popped_vertex == '0))
    else $error("empty response carries data");
`endif

endmodule

// ----- tb/heap_queue_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_queue_checker
// Watches the request, response and capacity channels of the heap queue,
// keeps its own copy of the heap to work out every response word, and
// compares each response word field by field with the oldest one due.
// ----------------------------------------------------------------------------
module heap_queue_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  bmhq_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  bmhq_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  bmhq_pkg::cfg_t cfg_data,
  output int unsigned    fail_count,
  output int unsigned    pending_words
);

  localparam int SLOTS = bmhq_pkg::HEAP_DEPTH_DEF;

  bmhq_pkg::key_t shadow_key [SLOTS];
  bmhq_pkg::vtx_t shadow_vtx [SLOTS];
  int unsigned    shadow_size;
  bmhq_pkg::cfg_t shadow_cap;
  bmhq_pkg::rsp_t due_responses [$];

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    bmhq_pkg::key_t k;
    bmhq_pkg::vtx_t v;
    k = shadow_key[a];
    v = shadow_vtx[a];
    shadow_key[a] = shadow_key[b];
    shadow_vtx[a] = shadow_vtx[b];
    shadow_key[b] = k;
    shadow_vtx[b] = v;
  endfunction

  // Applies one request word to the shadow heap and returns its response.
  function automatic bmhq_pkg::rsp_t heap_apply(input bmhq_pkg::req_t w);
    bmhq_pkg::rsp_t r;
    int unsigned    lim;
    int unsigned    i;
    int unsigned    p;
    int unsigned    lc;
    int unsigned    rc;
    int unsigned    s;
    r = '0;
    r.status = bmhq_pkg::ST_OK;
    if (w.mode == bmhq_pkg::MODE_INSERT) begin
      lim = (shadow_cap > SLOTS) ? SLOTS : shadow_cap;
      if (shadow_size >= lim) begin
        r.status = bmhq_pkg::ST_FULL;
      end else begin
        i = shadow_size;
        shadow_key[i] = w.distance_key;
        shadow_vtx[i] = w.vertex_id;
        shadow_size++;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (shadow_key[p] <= shadow_key[i]) break;
          swap_slots(i, p);
          i = p;
        end
      end
    end else if (shadow_size == 0) begin
      r.status = bmhq_pkg::ST_EMPTY;
    end else begin
      r.popped_vertex = shadow_vtx[0];
      shadow_key[0] = shadow_key[shadow_size - 1];
      shadow_vtx[0] = shadow_vtx[shadow_size - 1];
      shadow_size--;
      i = 0;
      forever begin
        lc = 2 * i + 1;
        rc = 2 * i + 2;
        s  = i;
        // Strict compares: the left child wins a tie, and an equal child
        // does not displace its parent.
        if (lc < shadow_size && shadow_key[lc] < shadow_key[s]) s = lc;
        if (rc < shadow_size && shadow_key[rc] < shadow_key[s]) s = rc;
        if (s == i) break;
        swap_slots(i, s);
        i = s;
      end
    end
    r.entry_count = bmhq_pkg::count_t'(shadow_size);
    return r;
  endfunction

  always @(posedge clk) begin
    bmhq_pkg::rsp_t want;
    if (rst) begin
      due_responses.delete();
      shadow_size = 0;
      shadow_cap  = bmhq_pkg::CAP_RESET;
      fail_count  = 0;
      pending_words <= 0;
    end else begin
      if (cfg_valid && cfg_ready) shadow_cap = cfg_data;
      // Responses are retired before new requests are queued, so a response
      // can never be matched against a request taken on the same edge.
      if (rsp_valid && !rsp_stall) begin
        if (due_responses.size() == 0) begin
          $error("unexpected response word %h", rsp);
          fail_count++;
        end else begin
          want = due_responses.pop_front();
          if (rsp.popped_vertex !== want.popped_vertex) begin
            $error("popped_vertex: expected %0h, got %0h", want.popped_vertex,
                   rsp.popped_vertex);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   rsp.entry_count);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall) due_responses.push_back(heap_apply(req));
      pending_words <= due_responses.size();
    end
  end

endmodule

// ----- tb/binary_min_heap_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_tb
// Drives the heap queue with a short directed sequence and then with random
// insert and extract words under a series of capacity settings, with random
// gaps on the request side and random stalls on the response side. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_tb;

  // Cycles without any accepted word before the run is declared hung. The
  // slowest operation and the random gaps and stalls are all short, so this is
  // generous by a wide margin.
  localparam int HANG_LIMIT = 3000;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  bmhq_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  bmhq_pkg::rsp_t rsp;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  bmhq_pkg::cfg_t cfg_data  = '0;

  // While calm is set neither side inserts gaps or stalls.
  logic           calm      = 1'b0;
  int unsigned    fail_count;
  int unsigned    pending_words;
  int unsigned    quiet_cycles = 0;

  always #5 clk = ~clk;

  binary_min_heap_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  heap_queue_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // The response side stalls in roughly a quarter of the cycles.
  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(0, 99) < 25);
  end

  // Hang detection: count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("binary_min_heap_queue test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bmhq_pkg::req_t insert_word(input bmhq_pkg::vtx_t v,
                                                 input bmhq_pkg::key_t k);
    bmhq_pkg::req_t w;
    w.mode         = bmhq_pkg::MODE_INSERT;
    w.vertex_id    = v;
    w.distance_key = k;
    return w;
  endfunction

  function automatic bmhq_pkg::req_t extract_word();
    bmhq_pkg::req_t w;
    w.mode         = bmhq_pkg::MODE_EXTRACT;
    w.vertex_id    = bmhq_pkg::vtx_t'($urandom());
    w.distance_key = bmhq_pkg::key_t'($urandom());
    return w;
  endfunction

  // Keys lean toward a handful of small values so that ties are common, and
  // toward the ends of the range.
  function automatic bmhq_pkg::key_t random_key();
    bmhq_pkg::key_t k;
    case ($urandom_range(0, 9))
      0:       k = '0;
      1:       k = '1;
      2, 3:    k = bmhq_pkg::key_t'($urandom_range(0, 7));
      4:       k = bmhq_pkg::key_t'(32'hFFFF_FFF8 | $urandom_range(0, 7));
      default: k = bmhq_pkg::key_t'($urandom());
    endcase
    return k;
  endfunction

  // Presents one word and holds it until it is taken. Valid stays high from
  // one word to the next unless a gap is chosen, so it is never lowered and
  // raised within the same step.
  task automatic send_word(input bmhq_pkg::req_t w);
    if (!calm) begin
      while ($urandom_range(0, 99) < 25) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall);
  endtask

  // Stops sending and waits until every response due has been taken. The
  // first edge lets the count pick up the word accepted just now.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The capacity is only changed while the block is idle.
  task automatic write_capacity(input bmhq_pkg::cfg_t cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input bmhq_pkg::cfg_t cap, input int count,
                           input int insert_pct, input bit quiet);
    bmhq_pkg::req_t w;
    write_capacity(cap);
    calm <= quiet;
    for (int k = 0; k < count; k++) begin
      w.mode         = ($urandom_range(0, 99) < insert_pct) ?
                       bmhq_pkg::MODE_INSERT : bmhq_pkg::MODE_EXTRACT;
      w.vertex_id    = bmhq_pkg::vtx_t'($urandom());
      w.distance_key = random_key();
      send_word(w);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity. An extract on the empty heap is
    // refused; then keys at both ends of the range and a run of equal keys
    // go in, so the drain checks tie handling (left child first, and no
    // move on an equal key) before ending on another empty extract.
    send_word(extract_word());
    send_word(insert_word(16'hFFFF, 32'hFFFF_FFFF));
    send_word(insert_word(16'h0000, 32'h0000_0000));
    send_word(insert_word(16'h0001, 32'h0000_0005));
    send_word(insert_word(16'h0002, 32'h0000_0005));
    send_word(insert_word(16'h0003, 32'h0000_0005));
    send_word(insert_word(16'h0004, 32'h8000_0000));
    send_word(insert_word(16'h0005, 32'h0000_0000));
    repeat (8) send_word(extract_word());

    // Random part. Small capacities hit the full case often; the capacity
    // of 1024 runs without gaps or stalls and lets the heap grow deep; a
    // value above the store depth is clamped; zero refuses every insert
    // while the heap still holds entries, which the last phase drains.
    run_phase(bmhq_pkg::cfg_t'(1),    100, 50, 1'b0);
    run_phase(bmhq_pkg::cfg_t'(2),    100, 55, 1'b0);
    run_phase(bmhq_pkg::cfg_t'(5),    150, 55, 1'b0);
    run_phase(bmhq_pkg::cfg_t'(17),   200, 60, 1'b0);
    run_phase(bmhq_pkg::cfg_t'($urandom_range(1, 64)), 200, 55, 1'b0);
    run_phase(bmhq_pkg::cfg_t'(1024), 400, 75, 1'b1);
    run_phase(bmhq_pkg::cfg_t'(2047), 150, 50, 1'b0);
    run_phase(bmhq_pkg::cfg_t'(0),     50, 50, 1'b0);
    run_phase(bmhq_pkg::cfg_t'(300),  400, 30, 1'b0);

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("binary_min_heap_queue test passed");
    end else begin
      $display("binary_min_heap_queue test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bmhq_pkg.sv
src/bmhq_ram.sv
src/binary_min_heap_queue.sv
tb/heap_queue_checker.sv
tb/binary_min_heap_queue_tb.sv
